// ===== hw/rtl/multi_source_audio_mixer_core_defines.svh =====
// assertion macros for the audio mixer core
`ifndef MULTI_SOURCE_AUDIO_MIXER_CORE_DEFINES_SVH
`define MULTI_SOURCE_AUDIO_MIXER_CORE_DEFINES_SVH

`ifndef SYNTH
// condition holds in the same cycle
`define MSAM_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("mixer check failed");
// condition holds in the following cycle
`define MSAM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("mixer check failed");
`else
`define MSAM_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define MSAM_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// ===== hw/rtl/msam_pkg.sv =====
// shared types, constants and helpers of the audio mixer core
package msam_pkg;

   // source and field geometry
   localparam int FIELD_SOURCES   = 4;
   localparam int SOURCES_DEFAULT = 4;
   localparam int SAMPLE_W        = 16;
   localparam int VOL_W           = 7;
   localparam int MODE_W          = 2;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 7;
   localparam int ACTIVE_W        = 3;
   localparam int NUM_STAGES      = 5;

   // lane arithmetic widths
   localparam int PROD_W          = SAMPLE_W + VOL_W + 1;
   localparam int MAG_W           = 22;
   localparam int RECIP_100_W     = 23;
   localparam int RECIP_100_SHIFT = 29;
   localparam int SCALED_W        = MAG_W + RECIP_100_W;
   localparam int QUOT_W          = SCALED_W - RECIP_100_SHIFT;
   localparam int TERM_W          = QUOT_W + 2;

   // merge arithmetic widths
   localparam int SUM_W           = TERM_W + 2;
   localparam int AVG_MAG_W       = SUM_W - 1;
   localparam int RECIP_3_W       = 19;
   localparam int RECIP_3_SHIFT   = 20;
   localparam int AVG_PROD_W      = AVG_MAG_W + RECIP_3_W;

   // ceil(2^29 / 100), exact floor for magnitudes below 2^22
   localparam logic [RECIP_100_W-1:0] RECIP_100 = RECIP_100_W'(5368710);
   // ceil(2^20 / 3), exact floor for magnitudes below 2^19
   localparam logic [RECIP_3_W-1:0]   RECIP_3   = RECIP_3_W'(349526);

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

   localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(100);

   // mix modes
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVG   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_SEL     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_0      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_1      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_2      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME_3      = 3'd5;

   // per-stage load enables of the pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } msam_adv_type;

   // clamp a wide signed value to the sample range
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [SAMPLE_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAMPLE_W'(SAT_HI);
      end else if (v < SAT_LO) begin
         r = SAMPLE_W'(SAT_LO);
      end else begin
         r = SAMPLE_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/msam_lane.sv =====
// one gain lane: sample times volume, divided by 100 toward zero
module msam_lane (
   input  logic                                   clock,
   input  msam_pkg::msam_adv_type                 adv,
   input  logic signed [msam_pkg::SAMPLE_W-1:0]   sample,
   input  logic        [msam_pkg::VOL_W-1:0]      volume,
   input  logic                                   src_used,
   output logic signed [msam_pkg::TERM_W-1:0]     term,
   output logic                                   term_used
);

   logic signed [msam_pkg::PROD_W-1:0]   prod_in, prod_ff;
   logic                                 used1_ff, used2_ff, used3_ff;
   logic        [msam_pkg::MAG_W-1:0]    mag;
   logic        [msam_pkg::SCALED_W-1:0] scaled_in, scaled_ff;
   logic                                 neg_in, neg_ff;
   logic        [msam_pkg::QUOT_W-1:0]   quot;
   logic signed [msam_pkg::TERM_W-1:0]   term_in, term_ff;

   // stage 1: signed product
   assign prod_in = msam_pkg::PROD_W'(sample)
                  * msam_pkg::PROD_W'($signed({1'b0, volume}));

   // stage 2: magnitude times reciprocal of 100
   assign neg_in    = prod_ff[msam_pkg::PROD_W-1];
   assign mag       = neg_in ? msam_pkg::MAG_W'(-prod_ff) : msam_pkg::MAG_W'(prod_ff);
   assign scaled_in = msam_pkg::SCALED_W'(mag) * msam_pkg::SCALED_W'(msam_pkg::RECIP_100);

   // stage 3: take quotient and restore sign
   assign quot    = scaled_ff[msam_pkg::SCALED_W-1:msam_pkg::RECIP_100_SHIFT];
   assign term_in = neg_ff ? -$signed(msam_pkg::TERM_W'(quot))
                           : $signed(msam_pkg::TERM_W'(quot));

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         prod_ff  <= prod_in;
         used1_ff <= src_used;
      end
      if (adv.s2) begin
         scaled_ff <= scaled_in;
         neg_ff    <= neg_in;
         used2_ff  <= used1_ff;
      end
      if (adv.s3) begin
         term_ff  <= term_in;
         used3_ff <= used2_ff;
      end
   end

   assign term      = term_ff;
   assign term_used = used3_ff;

endmodule

// ===== hw/rtl/msam_merge.sv =====
// merge of lane terms: first, saturating add, average or zero, then output register
module msam_merge (
   input  logic                                   clock,
   input  msam_pkg::msam_adv_type                 adv,
   input  logic        [msam_pkg::MODE_W-1:0]     blend_sel,
   input  logic        [msam_pkg::ACTIVE_W-1:0]   active,
   input  logic signed [msam_pkg::TERM_W-1:0]     terms [msam_pkg::FIELD_SOURCES],
   input  logic        [msam_pkg::FIELD_SOURCES-1:0] used,
   output logic signed [msam_pkg::SAMPLE_W-1:0]   mixed_sample
);

   logic signed [msam_pkg::SAMPLE_W-1:0]  first_val, acc_val;
   logic                                  found;
   logic signed [msam_pkg::SUM_W-1:0]     sum_in, sum_ff;
   logic signed [msam_pkg::SAMPLE_W-1:0]  pick_in, pick_ff;
   logic                                  avg_neg;
   logic        [msam_pkg::AVG_MAG_W-1:0] avg_mag, avg_quot;
   logic        [msam_pkg::AVG_PROD_W-1:0] avg_prod;
   logic signed [msam_pkg::SUM_W-1:0]     avg_val;
   logic signed [msam_pkg::SAMPLE_W-1:0]  mixed_in, mixed_ff;

   // stage 4: walk the lanes in source order
   always_comb begin
      first_val = '0;
      acc_val   = '0;
      found     = 1'b0;
      sum_in    = '0;
      for (int i = 0; i < msam_pkg::FIELD_SOURCES; i++) begin
         if (used[i]) begin
            if (!found) begin
               first_val = msam_pkg::sat_sample(msam_pkg::SUM_W'(terms[i]));
            end
            found   = 1'b1;
            acc_val = msam_pkg::sat_sample(msam_pkg::SUM_W'(acc_val)
                                           + msam_pkg::SUM_W'(terms[i]));
            sum_in  = sum_in + msam_pkg::SUM_W'(terms[i]);
         end
      end
      pick_in = (blend_sel == msam_pkg::MODE_ADD) ? acc_val : first_val;
   end

   // stage 5: divide the sum by the enabled count
   assign avg_neg  = sum_ff[msam_pkg::SUM_W-1];
   assign avg_mag  = avg_neg ? msam_pkg::AVG_MAG_W'(-sum_ff)
                             : msam_pkg::AVG_MAG_W'(sum_ff);
   assign avg_prod = msam_pkg::AVG_PROD_W'(avg_mag)
                   * msam_pkg::AVG_PROD_W'(msam_pkg::RECIP_3);

   always_comb begin
      case (active)
         3'd2:    avg_quot = avg_mag >> 1;
         3'd3:    avg_quot = msam_pkg::AVG_MAG_W'(avg_prod >> msam_pkg::RECIP_3_SHIFT);
         3'd4:    avg_quot = avg_mag >> 2;
         default: avg_quot = avg_mag;
      endcase
      avg_val = avg_neg ? -$signed(msam_pkg::SUM_W'(avg_quot))
                        : $signed(msam_pkg::SUM_W'(avg_quot));
   end

   // final selection
   always_comb begin
      if (active == '0) begin
         mixed_in = '0;
      end else begin
         case (blend_sel)
            msam_pkg::MODE_FIRST: mixed_in = pick_ff;
            msam_pkg::MODE_ADD:   mixed_in = pick_ff;
            msam_pkg::MODE_AVG:   mixed_in = msam_pkg::sat_sample(avg_val);
            default:              mixed_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         pick_ff <= pick_in;
         sum_ff  <= sum_in;
      end
      if (adv.s5) begin
         mixed_ff <= mixed_in;
      end
   end

   assign mixed_sample = mixed_ff;

endmodule

// ===== hw/rtl/multi_source_audio_mixer_core.sv =====
// top level of the multi-source audio mixer: registers, lanes, merge and flow control
//
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_sample_0..3, req_present_mask
// rsp     | out       | rsp_valid / rsp_ready | rsp_mixed_sample
// csr     | in        | csr_wen               | csr_index, csr_wdata
//
// one item per cycle sustained while rsp_ready is high; from accept to rsp_valid an item passes
// three lane stages for gain and divide by 100, then two merge stages
// each stage holds its item until the next stage is empty or moving, so empty
// stages keep taking items while a result waits on rsp_ready
// reset is synchronous: clears valid bits, mode and enables, volumes to 100
`include "multi_source_audio_mixer_core_defines.svh"

module multi_source_audio_mixer_core #(
   parameter int SOURCES = msam_pkg::SOURCES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [msam_pkg::SAMPLE_W-1:0]   req_sample_0,
   input  logic signed [msam_pkg::SAMPLE_W-1:0]   req_sample_1,
   input  logic signed [msam_pkg::SAMPLE_W-1:0]   req_sample_2,
   input  logic signed [msam_pkg::SAMPLE_W-1:0]   req_sample_3,
   input  logic        [msam_pkg::FIELD_SOURCES-1:0] req_present_mask,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [msam_pkg::SAMPLE_W-1:0]   rsp_mixed_sample,
   input  logic                                   csr_wen,
   input  logic        [msam_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [msam_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int LANES = (SOURCES < msam_pkg::FIELD_SOURCES) ? SOURCES
                                                             : msam_pkg::FIELD_SOURCES;
   localparam logic [msam_pkg::FIELD_SOURCES-1:0] LIMIT_MASK =
      msam_pkg::FIELD_SOURCES'((1 << LANES) - 1);

   logic [msam_pkg::MODE_W-1:0]        blend_sel_in, blend_sel_ff;
   logic [msam_pkg::FIELD_SOURCES-1:0] source_enable_in, source_enable_ff;
   logic [msam_pkg::VOL_W-1:0]         volume_in [msam_pkg::FIELD_SOURCES];
   logic [msam_pkg::VOL_W-1:0]         volume_ff [msam_pkg::FIELD_SOURCES];
   logic [msam_pkg::FIELD_SOURCES-1:0] enable_eff;
   logic [msam_pkg::ACTIVE_W-1:0]      active;

   logic [msam_pkg::NUM_STAGES-1:0]    valid_in, valid_ff, stage_rdy;
   msam_pkg::msam_adv_type             adv;

   logic signed [msam_pkg::SAMPLE_W-1:0] samples [msam_pkg::FIELD_SOURCES];
   logic signed [msam_pkg::TERM_W-1:0]   terms   [msam_pkg::FIELD_SOURCES];
   logic [msam_pkg::FIELD_SOURCES-1:0]   used;

   // register writes
   always_comb begin
      blend_sel_in     = blend_sel_ff;
      source_enable_in = source_enable_ff;
      for (int i = 0; i < msam_pkg::FIELD_SOURCES; i++) begin
         volume_in[i] = volume_ff[i];
      end
      if (csr_wen) begin
         case (csr_index)
            msam_pkg::CSR_BLEND_SEL:
               blend_sel_in = csr_wdata[msam_pkg::MODE_W-1:0];
            msam_pkg::CSR_SOURCE_ENABLE:
               source_enable_in = csr_wdata[msam_pkg::FIELD_SOURCES-1:0];
            msam_pkg::CSR_VOLUME_0: volume_in[0] = csr_wdata;
            msam_pkg::CSR_VOLUME_1: volume_in[1] = csr_wdata;
            msam_pkg::CSR_VOLUME_2: volume_in[2] = csr_wdata;
            msam_pkg::CSR_VOLUME_3: volume_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   // sources beyond the lane count stay disabled
   assign enable_eff = source_enable_ff & LIMIT_MASK;
   assign active     = msam_pkg::ACTIVE_W'($countones(enable_eff));

   // per-stage ready chain, each stage loads when empty or draining
   always_comb begin
      stage_rdy[msam_pkg::NUM_STAGES-1] = !valid_ff[msam_pkg::NUM_STAGES-1] || rsp_ready;
      for (int k = msam_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      valid_in[0] = stage_rdy[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < msam_pkg::NUM_STAGES; k++) begin
         valid_in[k] = stage_rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign adv.s1 = stage_rdy[0];
   assign adv.s2 = stage_rdy[1];
   assign adv.s3 = stage_rdy[2];
   assign adv.s4 = stage_rdy[3];
   assign adv.s5 = stage_rdy[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_sel_ff     <= msam_pkg::MODE_FIRST;
         source_enable_ff <= '0;
         for (int i = 0; i < msam_pkg::FIELD_SOURCES; i++) begin
            volume_ff[i] <= msam_pkg::VOL_RESET;
         end
         valid_ff <= '0;
      end else begin
         blend_sel_ff     <= blend_sel_in;
         source_enable_ff <= source_enable_in;
         for (int i = 0; i < msam_pkg::FIELD_SOURCES; i++) begin
            volume_ff[i] <= volume_in[i];
         end
         valid_ff <= valid_in;
      end
   end

   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;

   // gain lanes
   for (genvar g = 0; g < msam_pkg::FIELD_SOURCES; g++) begin : g_lane
      if (g < LANES) begin : g_on
         msam_lane u_lane (
            .clock     (clock),
            .adv       (adv),
            .sample    (samples[g]),
            .volume    (volume_ff[g]),
            .src_used  (req_present_mask[g] & enable_eff[g]),
            .term      (terms[g]),
            .term_used (used[g])
         );
      end else begin : g_off
         assign terms[g] = '0;
         assign used[g]  = 1'b0;
      end
   end

   // combine lanes
   msam_merge u_merge (
      .clock        (clock),
      .adv          (adv),
      .blend_sel    (blend_sel_ff),
      .active       (active),
      .terms        (terms),
      .used         (used),
      .mixed_sample (rsp_mixed_sample)
   );

   assign req_ready = stage_rdy[0];
   assign rsp_valid = valid_ff[msam_pkg::NUM_STAGES-1];

   // checks
   `MSAM_ASSERT_IMPLIES(a_zero_mode, clock, reset, rsp_valid && (blend_sel_ff == msam_pkg::MODE_ZERO), rsp_mixed_sample == '0)
   `MSAM_ASSERT_IMPLIES(a_none_enabled, clock, reset, rsp_valid && (enable_eff == '0), rsp_mixed_sample == '0)
   `MSAM_ASSERT_IMPLIES(a_ready_with_room, clock, reset, !(&valid_ff) || rsp_ready, req_ready)
   `MSAM_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready && !csr_wen, rsp_valid && $stable(rsp_mixed_sample))

endmodule
